### rtl/core/lss_pkg.sv
// Shared types, codes and reset values of the launcher speed sequencer.
package lss_pkg;

  localparam int FRACTION_BITS_DEF = 16;

  localparam int LEVEL_W = 8;
  localparam int WIDTH_W = 10;
  localparam int RATE_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int DISP_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [LEVEL_W-1:0] FAST_RST   = 8'd170;
  localparam logic [LEVEL_W-1:0] SLOW_RST   = 8'd117;
  localparam logic [LEVEL_W-1:0] STOP_RST   = 8'd100;
  localparam logic [RATE_W-1:0]  LIMIT_RST  = 16'hFFFF;
  localparam logic [WIDTH_W-1:0] MIN_RST    = 10'd100;
  localparam logic [WIDTH_W-1:0] MAX_RST    = 10'd900;
  localparam logic [GAIN_W-1:0]  GAIN_RST   = 16'd262;

  localparam logic [DISP_W-1:0] DISP_FAST = 5'd25;
  localparam logic [DISP_W-1:0] DISP_SLOW = 5'd15;
  localparam logic [DISP_W-1:0] DISP_NONE = 5'd0;

  typedef enum logic [1:0] {
    SW_UP   = 2'd0,
    SW_MID  = 2'd1,
    SW_DOWN = 2'd2,
    SW_NONE = 2'd3
  } sw_pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAST  = 3'd0,
    REG_SLOW  = 3'd1,
    REG_STOP  = 3'd2,
    REG_LIMIT = 3'd3,
    REG_MIN   = 3'd4,
    REG_MAX   = 3'd5,
    REG_GAIN  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] fast_level;
    logic [LEVEL_W-1:0] slow_level;
    logic [LEVEL_W-1:0] stop_level;
    logic [RATE_W-1:0]  feeder_limit;
    logic [WIDTH_W-1:0] min_width;
    logic [WIDTH_W-1:0] max_width;
    logic [GAIN_W-1:0]  smoothing_gain;
  } cfg_t;

  typedef struct packed {
    logic [RATE_W-1:0] feeder_rate;
    logic              toggle_key;
    sw_pos_t           right_switch;
    sw_pos_t           left_switch;
  } in_item_t;

  typedef struct packed {
    logic [DISP_W-1:0]  display_code;
    logic               armed;
    logic [WIDTH_W-1:0] target_width;
  } ctrl_res_t;

endpackage

### rtl/core/lss_cfg_regs.sv
// Configuration register file written through the configuration channel.
module lss_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [lss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lss_pkg::CFG_DATA_W-1:0]    cfg_data,
  output lss_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_level     <= lss_pkg::FAST_RST;
      cfg.slow_level     <= lss_pkg::SLOW_RST;
      cfg.stop_level     <= lss_pkg::STOP_RST;
      cfg.feeder_limit   <= lss_pkg::LIMIT_RST;
      cfg.min_width      <= lss_pkg::MIN_RST;
      cfg.max_width      <= lss_pkg::MAX_RST;
      cfg.smoothing_gain <= lss_pkg::GAIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lss_pkg::REG_FAST:  cfg.fast_level     <= cfg_data[lss_pkg::LEVEL_W-1:0];
        lss_pkg::REG_SLOW:  cfg.slow_level     <= cfg_data[lss_pkg::LEVEL_W-1:0];
        lss_pkg::REG_STOP:  cfg.stop_level     <= cfg_data[lss_pkg::LEVEL_W-1:0];
        lss_pkg::REG_LIMIT: cfg.feeder_limit   <= cfg_data[lss_pkg::RATE_W-1:0];
        lss_pkg::REG_MIN:   cfg.min_width      <= cfg_data[lss_pkg::WIDTH_W-1:0];
        lss_pkg::REG_MAX:   cfg.max_width      <= cfg_data[lss_pkg::WIDTH_W-1:0];
        lss_pkg::REG_GAIN:  cfg.smoothing_gain <= cfg_data[lss_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/lss_mode_ctrl.sv
// Switch and key decoding, level choice, clamp and safety gate of the setpoint.
module lss_mode_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  lss_pkg::in_item_t    item,
  input  lss_pkg::cfg_t        cfg,
  output lss_pkg::ctrl_res_t   res
);

  logic                          released, released_next;
  lss_pkg::sw_pos_t              last_right, last_right_next;
  logic                          key_held, key_held_next;
  logic [lss_pkg::LEVEL_W-1:0]   level, level_next;
  logic [lss_pkg::WIDTH_W-1:0]   setpoint, setpoint_next;
  logic [lss_pkg::WIDTH_W-1:0]   level_wide, clamped;

  always_comb begin
    released_next   = released | (item.right_switch == lss_pkg::SW_DOWN);
    last_right_next = last_right;
    key_held_next   = key_held;
    level_next      = level;

    case (item.left_switch)
      lss_pkg::SW_UP: begin
        if (last_right != item.right_switch) begin
          case (item.right_switch)
            lss_pkg::SW_UP:   level_next = cfg.fast_level;
            lss_pkg::SW_MID:  level_next = cfg.slow_level;
            lss_pkg::SW_DOWN: level_next = cfg.stop_level;
            default:          level_next = level;
          endcase
        end
        last_right_next = item.right_switch;
      end
      lss_pkg::SW_MID: begin
        // Only the press edge of the key swaps the level.
        if (item.toggle_key) begin
          if (!key_held) begin
            level_next = (level == cfg.slow_level) ? cfg.fast_level : cfg.slow_level;
          end
          key_held_next = 1'b1;
        end else begin
          key_held_next = 1'b0;
        end
      end
      default: ;
    endcase

    if (item.feeder_rate >= cfg.feeder_limit) begin
      level_next = cfg.slow_level;
    end

    level_wide = {{(lss_pkg::WIDTH_W - lss_pkg::LEVEL_W){1'b0}}, level_next};
    if (level_wide > cfg.max_width) begin
      clamped = cfg.max_width;
    end else if (level_wide < cfg.min_width) begin
      clamped = cfg.min_width;
    end else begin
      clamped = level_wide;
    end

    setpoint_next = (released_next || clamped <= cfg.min_width) ? clamped : setpoint;

    res.target_width = setpoint_next;
    res.armed        = released_next;
    if (level_next == cfg.fast_level) begin
      res.display_code = lss_pkg::DISP_FAST;
    end else if (level_next == cfg.slow_level) begin
      res.display_code = lss_pkg::DISP_SLOW;
    end else begin
      res.display_code = lss_pkg::DISP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      released   <= 1'b0;
      last_right <= lss_pkg::SW_NONE;
      key_held   <= 1'b0;
      level      <= '0;
      setpoint   <= '0;
    end else if (adv) begin
      released   <= released_next;
      last_right <= last_right_next;
      key_held   <= key_held_next;
      level      <= level_next;
      setpoint   <= setpoint_next;
    end
  end

  // The safety release is a latch that only reset clears.
  a_release_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(released) |-> released)
    else $error("safety release dropped without reset");

  // Control state moves only when an item passes through.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(adv) |-> $stable(level) && $stable(setpoint) && $stable(key_held))
    else $error("control state changed without an item");

endmodule

### rtl/core/lss_filter.sv
// Exponential smoothing of the setpoint with an unsigned fixed-point accumulator.
module lss_filter #(
  parameter int FRACTION_BITS = lss_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic [lss_pkg::WIDTH_W-1:0]    setpoint,
  input  logic [lss_pkg::GAIN_W-1:0]     gain,
  output logic [lss_pkg::WIDTH_W-1:0]    pwm_width
);

  localparam int AW = lss_pkg::WIDTH_W + FRACTION_BITS;
  localparam int PW = AW + lss_pkg::GAIN_W;
  localparam logic [AW-1:0] ACC_MAX = {{lss_pkg::WIDTH_W{1'b1}}, {FRACTION_BITS{1'b0}}};

  logic [AW-1:0] acc, acc_next;
  logic [AW-1:0] tgt, diff, step;
  logic          rising;
  logic [PW-1:0] prod, prod_up;

  always_comb begin
    tgt    = {setpoint, {FRACTION_BITS{1'b0}}};
    rising = (tgt >= acc);
    diff   = rising ? (tgt - acc) : (acc - tgt);
    prod   = {{lss_pkg::GAIN_W{1'b0}}, diff} * {{AW{1'b0}}, gain};
    // Falling steps round up so the accumulator floors toward minus infinity.
    prod_up = prod + {{(PW - lss_pkg::GAIN_W){1'b0}}, {lss_pkg::GAIN_W{1'b1}}};
    step    = rising ? prod[PW-1:lss_pkg::GAIN_W] : prod_up[PW-1:lss_pkg::GAIN_W];
    acc_next = rising ? (acc + step) : (acc - step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv) begin
      acc <= acc_next;
    end
  end

  assign pwm_width = acc[AW-1:FRACTION_BITS];

  a_acc_range: assert property (@(posedge clk) disable iff (rst) acc <= ACC_MAX)
    else $error("filter accumulator out of range");

  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(adv) |-> $stable(acc))
    else $error("filter accumulator changed without an item");

endmodule

### rtl/core/launcher_speed_sequencer.sv
// Top level of the launcher speed sequencer: input stage, control stage, filter output stage.
//
// Channel  Direction  Handshake                    Content
// s_*      in         s_tvalid / s_tready          one control tick
// m_*      out        m_tvalid / m_tready          pulse width, setpoint, armed, display
// cfg_*    in         cfg_valid / cfg_ready        register index and write data
//
// An item passes three registers: input, control result, filter output.
// m_tvalid is the output stage's valid; one item per cycle passes while m_tready is high.
// The combinational loop through the filter accumulator (subtract, 26x16 multiply, add)
// sets the clock period. Each stage holds its item while the next stage is full, so a held
// result does not stop earlier stages from filling. Reset is synchronous, clears all
// control state, loads the config registers with reset values; cfg_ready is always high.
module launcher_speed_sequencer #(
  parameter int FRACTION_BITS = lss_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // left_switch[1:0], right_switch[3:2], toggle_key[4], feeder_rate[20:5], zero[23:21]
  input  logic [lss_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // pwm_width[9:0], target_width[19:10], armed[20], display_code[25:21], zero[31:26]
  output logic [lss_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lss_pkg::cfg_t      cfg;
  lss_pkg::in_item_t  in_item;
  lss_pkg::ctrl_res_t ctrl_res, mid_res, out_res;
  logic               in_valid, mid_valid, out_valid;
  logic               in_ready, mid_ready, out_ready;
  logic               in_adv, mid_adv;
  logic [lss_pkg::WIDTH_W-1:0] pwm_width;

  assign cfg_ready = 1'b1;

  lss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_ready = !out_valid || m_tready;
  assign mid_ready = !mid_valid || out_ready;
  assign in_ready  = !in_valid || mid_ready;
  assign s_tready  = in_ready;
  assign in_adv    = in_valid && mid_ready;
  assign mid_adv   = mid_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready)  in_valid  <= s_tvalid;
      if (mid_ready) mid_valid <= in_valid;
      if (out_ready) out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && in_ready) begin
      in_item.left_switch  <= lss_pkg::sw_pos_t'(s_tdata[1:0]);
      in_item.right_switch <= lss_pkg::sw_pos_t'(s_tdata[3:2]);
      in_item.toggle_key   <= s_tdata[4];
      in_item.feeder_rate  <= s_tdata[20:5];
    end
    if (in_adv) mid_res <= ctrl_res;
    if (mid_adv) out_res <= mid_res;
  end

  lss_mode_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .adv  (in_adv),
    .item (in_item),
    .cfg  (cfg),
    .res  (ctrl_res)
  );

  lss_filter #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_filter (
    .clk       (clk),
    .rst       (rst),
    .adv       (mid_adv),
    .setpoint  (mid_res.target_width),
    .gain      (cfg.smoothing_gain),
    .pwm_width (pwm_width)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.display_code, out_res.armed,
                     out_res.target_width, pwm_width};

  // An empty output register always lets the whole pipeline accept.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled while output register is empty");

  // An item in the control stage moves on whenever the output side is free.
  a_mid_moves: assert property (@(posedge clk) disable iff (rst)
    mid_valid && !out_valid |=> out_valid)
    else $error("control result did not reach the output register");

endmodule
